// ===== rtl/core/s2a_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds field widths, character codes and the divide-by-ten reciprocal.
// No dependencies; every other file of the block imports it.
`default_nettype none

package s2a_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;
    // Widest magnitude is 2147483648, which has ten digits.
    localparam int MAX_DIGITS = 10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // floor(n / 10) == (n * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit n.
    localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int                 DIV10_SHIFT = 35;

    typedef logic [VALUE_W-1:0] t_mag;
    typedef logic [DIGIT_W-1:0] t_digit;

endpackage : s2a_pkg

`default_nettype wire

// ===== rtl/core/s2a_if.sv =====
// Valid/ready channel interfaces for the decimal ASCII converter.
// Depends on s2a_pkg for the payload widths.
`default_nettype none

interface s2a_in_if
    import s2a_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface : s2a_in_if

interface s2a_out_if
    import s2a_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ascii_char;
    logic              is_last;

    modport source (output valid, output ascii_char, output is_last, input ready);
    modport sink   (input valid, input ascii_char, input is_last, output ready);
endinterface : s2a_out_if

`default_nettype wire

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// Channel    | Dir | Payload                    | Per transaction
// i_in       | in  | value (32-bit signed)      | one integer to convert
// o_out      | out | ascii_char (8), is_last(1) | one character, 1 to 11 per integer
//
// An integer is taken in S_IDLE, then for each digit the shared divide-by-ten unit
// is used in S_DIV and S_STORE (multiply, then write back), then one character
// leaves per cycle while the output is not stalled.
// i_in.ready is high only while the sequencer is idle; the output register
// holds a stalled character and the sequencer waits on it.
// Reset is synchronous, active low, and clears the sequencer and output valid.
// Top level of the converter; uses s2a_pkg, s2a_if and s2a_div10.
`default_nettype none

module signed_int_to_decimal_ascii
    import s2a_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    s2a_in_if.sink     i_in,
    s2a_out_if.source  o_out
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_STORE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_mag              r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [3:0]        r_ndig, n_ndig;
    logic [3:0]        r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;
    t_digit            r_digits [MAX_DIGITS];

    logic              w_start;
    logic              w_wr;
    logic              w_done;
    t_mag              w_quot;
    t_digit            w_rem;
    t_mag              w_raw;
    t_mag              w_abs;
    logic              w_slot_free;

    s2a_div10 u_div10 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_mag),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Two's complement negate; the most negative value maps to 2^31, which fits.
    assign w_raw       = i_in.value;
    assign w_abs       = w_raw[VALUE_W-1] ? (VALUE_W'(0) - w_raw) : w_raw;
    assign w_slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_ndig      = r_ndig;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_start     = 1'b0;
        w_wr        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_neg   = w_raw[VALUE_W-1];
                    n_mag   = w_abs;
                    n_ndig  = 4'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                w_start = 1'b1;
                n_state = S_STORE;
            end
            S_STORE: begin
                if (w_done) begin
                    w_wr   = 1'b1;
                    n_mag  = w_quot;
                    n_ndig = r_ndig + 4'd1;
                    if (w_quot == '0 || r_ndig == 4'(MAX_DIGITS - 1)) begin
                        n_idx   = r_ndig;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        // At least one digit always follows the sign.
                        n_out_char = CHAR_MINUS;
                        n_out_last = 1'b0;
                        n_neg      = 1'b0;
                    end else begin
                        n_out_char = CHAR_ZERO + {4'b0000, r_digits[r_idx]};
                        n_out_last = (r_idx == 4'd0);
                        if (r_idx == 4'd0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx - 4'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_ndig     <= n_ndig;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // Digits are stored least significant first and read back in reverse.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_digits[r_ndig] <= w_rem;
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.ascii_char = r_out_char;
    assign o_out.is_last    = r_out_last;

endmodule : signed_int_to_decimal_ascii

`default_nettype wire

// ===== rtl/core/s2a_div10.sv =====
// Shared divide-by-ten unit: one reciprocal multiply, result registered.
// Returns quotient and remainder in the cycle after a start. Uses s2a_pkg.
`default_nettype none

module s2a_div10
    import s2a_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_mag   i_dividend,
    output logic        o_done,
    output t_mag        o_quot,
    output t_digit      o_rem
);

    logic [2*VALUE_W-1:0] w_prod;
    t_mag                 w_quot;
    t_digit               w_q10_lo;
    t_digit               w_rem;
    logic                 r_done;
    t_mag                 r_quot;
    t_digit               r_rem;

    assign w_prod = (2*VALUE_W)'(i_dividend) * (2*VALUE_W)'(DIV10_RECIP);
    assign w_quot = VALUE_W'(w_prod[2*VALUE_W-1:DIV10_SHIFT]);

    // The remainder is below ten, so only the low four bits of n - 10q matter.
    assign w_q10_lo = {w_quot[0], 3'b000} + {w_quot[2:0], 1'b0};
    assign w_rem    = i_dividend[DIGIT_W-1:0] - w_q10_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= w_quot;
            r_rem  <= w_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule : s2a_div10

`default_nettype wire

// ===== rtl/core/s2a_checker.sv =====
// Port-level checks for the decimal ASCII converter and the bind that attaches them.
// Depends on s2a_pkg and on the top level signed_int_to_decimal_ascii.
`default_nettype none

module s2a_checker
    import s2a_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [CHAR_W-1:0] i_out_char,
    input wire logic              i_out_last
);

    // A stalled character must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_char) && $stable(i_out_last)))
        else $error("stalled output transaction changed");

    // The converter is not ready in the cycle after taking an integer.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted transaction");

    // Only a minus sign or a decimal digit ever appears.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char == CHAR_MINUS ||
                         (i_out_char >= CHAR_ZERO && i_out_char <= CHAR_NINE)))
        else $error("output character is neither a sign nor a digit");

    // The text never ends on a sign.
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_last) |-> (i_out_char != CHAR_MINUS))
        else $error("last character is a minus sign");

    // A digit is presented right after the sign is taken.
    a_digit_after_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_char == CHAR_MINUS) |=>
            (i_out_valid && i_out_char != CHAR_MINUS))
        else $error("no digit follows the minus sign");

endmodule : s2a_checker

bind signed_int_to_decimal_ascii s2a_checker u_s2a_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.ascii_char),
    .i_out_last  (o_out.is_last)
);

`default_nettype wire

// ===== dv/signed_int_to_decimal_ascii_checker.sv =====
// Checker for the signed integer to decimal ASCII converter: watches both
// channels, predicts the character text of every integer and compares it.
// Depends on s2a_pkg for widths and character codes.
module signed_int_to_decimal_ascii_checker
    import s2a_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [VALUE_W-1:0] i_in_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [CHAR_W-1:0]  i_out_char,
    input  logic               i_out_last,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DECIMAL_BASE = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              is_last;
    } t_text_char;

    t_text_char expected_text[$];
    int         error_count;
    int         chars_checked;

    initial begin
        error_count   = 0;
        chars_checked = 0;
        o_errors        = 0;
        o_pending       = 0;
        o_chars_checked = 0;
    end

    // Appends the decimal text of one integer, sign first, most significant
    // digit first. The most negative value keeps its true magnitude because
    // the unsigned negation of 0x80000000 is 2147483648.
    function automatic void queue_decimal_text(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        t_digit             digits[MAX_DIGITS];
        int                 ndig;
        t_text_char         entry;
        mag  = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
        ndig = 0;
        do begin
            digits[ndig] = t_digit'(mag % DECIMAL_BASE);
            ndig++;
            mag = mag / DECIMAL_BASE;
        end while (mag != 0);
        if (raw[VALUE_W-1]) begin
            entry.ascii_char = CHAR_MINUS;
            entry.is_last    = 1'b0;
            expected_text.push_back(entry);
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            entry.ascii_char = CHAR_ZERO + {4'h0, digits[k]};
            entry.is_last    = (k == 0);
            expected_text.push_back(entry);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            // Characters of an earlier integer are compared before the text
            // of an integer taken at the same edge is queued.
            if (i_out_valid && i_out_ready) begin
                chars_checked++;
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected character, expected none, actual %h last %b",
                             $time, i_out_char, i_out_last);
                    error_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (want.ascii_char != i_out_char) begin
                        $display("%0t: ascii_char mismatch, expected %h, actual %h",
                                 $time, want.ascii_char, i_out_char);
                        error_count++;
                    end
                    if (want.is_last != i_out_last) begin
                        $display("%0t: is_last mismatch, expected %b, actual %b",
                                 $time, want.is_last, i_out_last);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                queue_decimal_text(i_in_value);
            end
        end
        o_errors        <= error_count;
        o_pending       <= expected_text.size();
        o_chars_checked <= chars_checked;
    end

endmodule : signed_int_to_decimal_ascii_checker

// ===== dv/signed_int_to_decimal_ascii_test.sv =====
// Top of the testbench for signed_int_to_decimal_ascii: clock, reset,
// integer stimulus and random output stalls; the checker does the comparing.
// Depends on s2a_pkg, s2a_if, the block and signed_int_to_decimal_ascii_checker.
module signed_int_to_decimal_ascii_test
    import s2a_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 250;
    localparam int QUIET_ITEMS    = 40;
    localparam int DRAIN_EVERY    = 60;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    s2a_in_if  in_ch ();
    s2a_out_if out_ch ();

    int errors;
    int pending;
    int chars_checked;
    int items_sent;
    int negatives_sent;
    bit idle_on;
    int stuck_cycles;

    signed_int_to_decimal_ascii u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    signed_int_to_decimal_ascii_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_in_value      (in_ch.value),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_out_char      (out_ch.ascii_char),
        .i_out_last      (out_ch.is_last),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_chars_checked (chars_checked)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Any cycle without a transaction on either channel counts toward the limit.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Output side: runs of ready broken by stall bursts while idling is on.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (idle_on && $urandom_range(0, 1) == 1) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
    end

    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (v < 0) negatives_sent++;
    endtask

    // Holds the input channel low until every queued character has arrived.
    task automatic drain_text();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Mostly values of a random digit count and sign, the rest any 32-bit pattern.
    function automatic logic signed [VALUE_W-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     ndig;
        if ($urandom_range(0, 3) == 0) return $urandom();
        ndig = $urandom_range(1, 10);
        lo   = (ndig == 1) ? 0 : longint'(10) ** (ndig - 1);
        hi   = longint'(10) ** ndig - 1;
        if (hi > 2147483647) hi = 2147483647;
        mag = lo + $urandom_range(0, int'(hi - lo));
        return ($urandom_range(0, 1) == 1) ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    initial begin
        logic signed [VALUE_W-1:0] directed[$];
        directed = '{0, 1, -1, 7, -7, 9, 10, -10, 99, 100, -100,
                     999999999, -999999999, 1000000000, 1234567890, -1234567890,
                     32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
                     32'sh55555555, 32'shAAAAAAAA, 32'shFFFFFFF6};
        items_sent     = 0;
        negatives_sent = 0;
        stuck_cycles   = 0;
        idle_on        = 1'b1;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.value    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_value(directed[i]);
        drain_text();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1) drain_text();
            send_value(random_value());
        end

        drain_text();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d integers (%0d negative) and compared %0d characters,",
                 items_sent, negatives_sent, chars_checked);
        $display("covering sign and digit-count extremes with stalls on both channels.");
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule : signed_int_to_decimal_ascii_test
